@@ hdl/u8c_pkg.sv @@
`default_nettype none
package u8c_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] ST_DECODED = 2'd0;
  localparam logic [1:0] ST_BYTE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [20:0] MaxPoint   = 21'h10FFFF;
  localparam logic [20:0] Max1Byte   = 21'h00007F;
  localparam logic [20:0] Max2Byte   = 21'h0007FF;
  localparam logic [20:0] Max3Byte   = 21'h00FFFF;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;
  localparam logic [1:0] ContTag = 2'b10;

  // One queued job: a single result, or an encoded burst of count beats.
  typedef struct packed {
    logic [1:0]      status;
    logic [30:0]     point;
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } job_t;

endpackage
`default_nettype wire

@@ hdl/u8c_front.sv @@
`default_nettype none
module u8c_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic         opcode,
  input  wire logic [7:0]   in_byte,
  input  wire logic [20:0]  code_point,
  input  wire logic         end_of_input,
  input  wire logic [2:0]   room,
  output u8c_pkg::job_t     job,
  output logic              push
);

  logic [30:0] partial_value;
  logic [2:0]  bytes_remaining;
  logic [2:0]  sequence_total;
  logic [30:0] partial_value_next;
  logic [2:0]  bytes_remaining_next;
  logic [2:0]  sequence_total_next;

  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    if (!b[7]) n = 4'd0;
    else if (!b[6]) n = 4'd1;
    else if (!b[5]) n = 4'd2;
    else if (!b[4]) n = 4'd3;
    else if (!b[3]) n = 4'd4;
    else if (!b[2]) n = 4'd5;
    else if (!b[1]) n = 4'd6;
    else if (!b[0]) n = 4'd7;
    else n = 4'd8;
    return n;
  endfunction

  u8c_pkg::job_t dec_job;
  u8c_pkg::job_t enc_job;
  logic          dec_push;
  logic [3:0]    n_ones;
  logic [30:0]   pv;
  logic [2:0]    rem;
  logic [2:0]    tot;
  logic          bad;

  always_comb begin
    n_ones = lead_ones(in_byte);
    pv = partial_value;
    rem = bytes_remaining;
    tot = sequence_total;
    bad = 1'b0;
    dec_push = 1'b0;
    dec_job = '0;
    dec_job.count = 3'd1;
    if (bytes_remaining != 3'd0) begin
      if (in_byte[7:6] != u8c_pkg::ContTag) begin
        bad = 1'b1;
      end else begin
        pv = {partial_value[24:0], in_byte[5:0]};
        rem = bytes_remaining - 3'd1;
      end
    end else begin
      case (n_ones)
        4'd0: ;
        4'd2: pv = {26'd0, in_byte[4:0]};
        4'd3: pv = {27'd0, in_byte[3:0]};
        4'd4: pv = {28'd0, in_byte[2:0]};
        4'd5: pv = {29'd0, in_byte[1:0]};
        4'd6: pv = {30'd0, in_byte[0]};
        default: bad = 1'b1;
      endcase
      if (n_ones >= 4'd2 && n_ones <= 4'd6) begin
        tot = n_ones[2:0];
        rem = n_ones[2:0] - 3'd1;
      end
    end
    partial_value_next = pv;
    bytes_remaining_next = rem;
    sequence_total_next = tot;
    if (bad) begin
      dec_push = 1'b1;
      dec_job.status = u8c_pkg::ST_INVALID;
      partial_value_next = '0;
      bytes_remaining_next = '0;
      sequence_total_next = '0;
    end else if (bytes_remaining == 3'd0 && n_ones == 4'd0) begin
      dec_push = 1'b1;
      dec_job.status = u8c_pkg::ST_DECODED;
      dec_job.point = {23'd0, in_byte};
      dec_job.len = 3'd1;
    end else if (rem == 3'd0) begin
      dec_push = 1'b1;
      dec_job.status = u8c_pkg::ST_DECODED;
      dec_job.point = pv;
      dec_job.len = tot;
      partial_value_next = '0;
      bytes_remaining_next = '0;
      sequence_total_next = '0;
    end else if (end_of_input) begin
      dec_push = 1'b1;
      dec_job.status = u8c_pkg::ST_SHORT;
      partial_value_next = '0;
      bytes_remaining_next = '0;
      sequence_total_next = '0;
    end
  end

  logic [2:0]      enc_n;
  logic [3:0][7:0] enc_bytes;

  always_comb begin
    enc_bytes = '0;
    if (code_point <= u8c_pkg::Max1Byte) begin
      enc_n = 3'd1;
      enc_bytes[0] = {1'b0, code_point[6:0]};
    end else if (code_point <= u8c_pkg::Max2Byte) begin
      enc_n = 3'd2;
      enc_bytes[0] = u8c_pkg::Lead2 | {3'd0, code_point[10:6]};
      enc_bytes[1] = u8c_pkg::Cont | {2'd0, code_point[5:0]};
    end else if (code_point <= u8c_pkg::Max3Byte) begin
      enc_n = 3'd3;
      enc_bytes[0] = u8c_pkg::Lead3 | {4'd0, code_point[15:12]};
      enc_bytes[1] = u8c_pkg::Cont | {2'd0, code_point[11:6]};
      enc_bytes[2] = u8c_pkg::Cont | {2'd0, code_point[5:0]};
    end else begin
      enc_n = 3'd4;
      enc_bytes[0] = u8c_pkg::Lead4 | {5'd0, code_point[20:18]};
      enc_bytes[1] = u8c_pkg::Cont | {2'd0, code_point[17:12]};
      enc_bytes[2] = u8c_pkg::Cont | {2'd0, code_point[11:6]};
      enc_bytes[3] = u8c_pkg::Cont | {2'd0, code_point[5:0]};
    end
    enc_job = '0;
    enc_job.count = 3'd1;
    if (code_point > u8c_pkg::MaxPoint) begin
      enc_job.status = u8c_pkg::ST_INVALID;
    end else if (room < enc_n) begin
      enc_job.status = u8c_pkg::ST_SHORT;
    end else begin
      enc_job.status = u8c_pkg::ST_BYTE;
      enc_job.len = enc_n;
      enc_job.bytes = enc_bytes;
      enc_job.count = enc_n;
    end
  end

  always_comb begin
    if (opcode == u8c_pkg::OP_ENCODE) begin
      job = enc_job;
      push = accept;
    end else begin
      job = dec_job;
      push = accept && dec_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_remaining <= '0;
      sequence_total <= '0;
    end else if (accept && opcode == u8c_pkg::OP_DECODE) begin
      partial_value <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_total <= sequence_total_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/u8c_queue.sv @@
`default_nettype none
module u8c_queue #(
  parameter int unsigned DEPTH = u8c_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  u8c_pkg::job_t      push_job,
  input  wire logic          pop,
  output u8c_pkg::job_t      head,
  output logic               full,
  output logic               not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  u8c_pkg::job_t   slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;

  assign full = (fill == (PtrW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign head = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) r = '0;
    else r = p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wr_ptr <= bump(wr_ptr);
      if (pop && not_empty) rd_ptr <= bump(rd_ptr);
      case ({push && !full, pop && not_empty})
        2'b10: fill <= fill + (PtrW+1)'(1);
        2'b01: fill <= fill - (PtrW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/u8c_back.sv @@
`default_nettype none
module u8c_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  u8c_pkg::job_t     job,
  input  wire logic         job_valid,
  output logic              job_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        status,
  output logic [30:0]       decoded_point,
  output logic [2:0]        seq_length,
  output logic [7:0]        out_byte,
  output logic              last
);

  logic [1:0] beat_idx;
  logic       load;
  logic       final_beat;

  assign load = job_valid && (!out_valid || out_ready);
  assign final_beat = ({1'b0, beat_idx} == (job.count - 3'd1));
  assign job_pop = load && final_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_idx <= final_beat ? 2'd0 : beat_idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= job.status;
      decoded_point <= job.point;
      seq_length <= job.len;
      out_byte <= job.bytes[beat_idx];
      last <= final_beat;
    end
  end

endmodule
`default_nettype wire

@@ hdl/utf8_codec.sv @@
// UTF-8 codec: one byte decoded or one code point encoded per beat.
// Results pass a queue slot, then the output register. Throughput: one input beat
// per cycle while the queue is not full; an encode emits 1 to 4 beats, one per cycle
// unless stalled; the single output register and the queue set the sustained rate.
// Reset (rst, synchronous): clears the decode state, the job queue and output valid.
`default_nettype none
module utf8_codec #(
  parameter int unsigned QDEPTH = u8c_pkg::QueueDepth
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         opcode,
  input  wire logic [7:0]   in_byte,
  input  wire logic [20:0]  code_point,
  input  wire logic         end_of_input,
  input  wire logic [2:0]   room,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        status,
  output logic [30:0]       decoded_point,
  output logic [2:0]        seq_length,
  output logic [7:0]        out_byte,
  output logic              last
);

  u8c_pkg::job_t new_job;
  u8c_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          not_empty;

  assign in_ready = !full;

  u8c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_valid && in_ready),
    .opcode       (opcode),
    .in_byte      (in_byte),
    .code_point   (code_point),
    .end_of_input (end_of_input),
    .room         (room),
    .job          (new_job),
    .push         (push)
  );

  u8c_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (new_job),
    .pop       (pop),
    .head      (head_job),
    .full      (full),
    .not_empty (not_empty)
  );

  u8c_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (head_job),
    .job_valid     (not_empty),
    .job_pop       (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .decoded_point (decoded_point),
    .seq_length    (seq_length),
    .out_byte      (out_byte),
    .last          (last)
  );

endmodule
`default_nettype wire
